// File: hdl/contrast_stretch_minmax_assert.svh
// Assertion macros shared by the contrast stretch RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef CONTRAST_STRETCH_MINMAX_ASSERT_SVH
`define CONTRAST_STRETCH_MINMAX_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/csm_pkg.sv
// Package for the min/max contrast stretch block: payload structs, FSM states,
// controller-datapath command/status types and fixed constants. No dependencies.
`default_nettype none

package csm_pkg;

  localparam int NUM_CH     = 4;
  localparam int PIX_W      = 8;
  localparam int DIV_STEPS  = 8;                   // quotient bits
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int NUM_W      = 17;                  // (p-min)*510 + range
  localparam int DEN_W      = 9;                   // 2 * range
  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

  // function codes of an input item
  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_ADJUST  = 1'b1;

  typedef struct packed {
    logic             func;
    logic             first;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } csm_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [PIX_W-1:0] alpha_out;
  } csm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } csm_state_t;

  // controller to datapath
  typedef struct packed {
    logic              measure;   // measure item transferred, update marks
    logic              load;      // adjust item transferred, set up divide
    logic              step;      // one restoring divide step
    logic [STEP_W-1:0] bit_idx;   // quotient bit resolved by this step
    logic              emit;      // load the output register
  } csm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;               // output register holds an untaken result
  } csm_sts_t;

endpackage

`default_nettype wire

// File: hdl/csm_ctrl.sv
// Controller FSM for the contrast stretch block: input handshake and divide sequencing.
// Depends on csm_pkg and contrast_stretch_minmax_assert.svh.
`default_nettype none

`include "contrast_stretch_minmax_assert.svh"

module csm_ctrl
  import csm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     in_func,
  input  wire csm_sts_t sts,
  output csm_cmd_t      cmd
);

  csm_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              xfer;

  assign in_ready = (state_r == ST_IDLE);
  assign xfer     = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (xfer && in_func == FUNC_ADJUST) begin
          state_nxt = ST_DIV;
          cnt_nxt   = STEP_W'(DIV_STEPS - 1);
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.measure = xfer && (in_func == FUNC_MEASURE);
        cmd.load    = xfer && (in_func == FUNC_ADJUST);
      end
      ST_DIV: begin
        cmd.step    = 1'b1;
        cmd.bit_idx = cnt_r;
      end
      ST_EMIT: begin
        cmd.emit = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `CSM_ASSERT_NEXT(a_load_starts_div, cmd.load, (state_r == ST_DIV) && (cnt_r == STEP_W'(DIV_STEPS - 1)), "adjust transfer did not start a full divide")
  `CSM_ASSERT_NEXT(a_div_ends_emit, (state_r == ST_DIV) && (cnt_r == '0), state_r == ST_EMIT, "divide did not end in emit")
  `CSM_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.measure, cmd.load, cmd.step, cmd.emit}), "more than one command")

endmodule

`default_nettype wire

// File: hdl/csm_dp.sv
// Datapath for the contrast stretch block: per-channel marks, four-lane restoring
// divider and the output register. Depends on csm_pkg and the assertion header.
`default_nettype none

`include "contrast_stretch_minmax_assert.svh"

module csm_dp
  import csm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  input  wire csm_in_t  in_data,
  input  wire csm_cmd_t cmd,
  output csm_sts_t      sts,
  output logic          out_valid,
  input  wire logic     out_ready,
  output csm_out_t      out_data
);

  logic                 has_alpha_r;
  logic [PIX_W-1:0]     px [NUM_CH];

  logic [PIX_W-1:0]     lo_r [NUM_CH], lo_nxt [NUM_CH];
  logic [PIX_W-1:0]     hi_r [NUM_CH], hi_nxt [NUM_CH];
  logic [NUM_W-1:0]     rem_r [NUM_CH], rem_nxt [NUM_CH];
  logic [DEN_W-1:0]     den_r [NUM_CH], den_nxt [NUM_CH];
  logic [PIX_W-1:0]     q_r [NUM_CH], q_nxt [NUM_CH];
  logic                 ovr_r [NUM_CH], ovr_nxt [NUM_CH];
  logic [PIX_W-1:0]     ovr_val_r [NUM_CH], ovr_val_nxt [NUM_CH];
  logic [PIX_W-1:0]     res [NUM_CH];

  logic                 out_valid_r, out_valid_nxt;
  csm_out_t             out_r, out_nxt;

  // pixel lanes; alpha reads as zero without an alpha byte
  always_comb begin
    px[0] = in_data.red;
    px[1] = in_data.green;
    px[2] = in_data.blue;
    px[3] = has_alpha_r ? in_data.alpha : '0;
  end

  // marks and divider lanes
  always_comb begin
    logic [PIX_W-1:0] diff;
    logic [PIX_W-1:0] rng;
    logic [NUM_W-1:0] dsh;
    logic [NUM_W:0]   trial;
    diff  = '0;
    rng   = '0;
    dsh   = '0;
    trial = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      lo_nxt[c]      = lo_r[c];
      hi_nxt[c]      = hi_r[c];
      rem_nxt[c]     = rem_r[c];
      den_nxt[c]     = den_r[c];
      q_nxt[c]       = q_r[c];
      ovr_nxt[c]     = ovr_r[c];
      ovr_val_nxt[c] = ovr_val_r[c];

      // measure: first pixel reloads, otherwise track min and max
      if (cmd.measure) begin
        if (in_data.first) begin
          lo_nxt[c] = px[c];
          hi_nxt[c] = px[c];
        end else begin
          if (px[c] < lo_r[c]) lo_nxt[c] = px[c];
          if (px[c] > hi_r[c]) hi_nxt[c] = px[c];
        end
      end

      // adjust set-up: numerator (p-min)*510 + range, divisor 2*range
      if (cmd.load) begin
        diff           = px[c] - lo_r[c];
        rng            = hi_r[c] - lo_r[c];
        rem_nxt[c]     = {diff, 9'b0} - {8'b0, diff, 1'b0} + {9'b0, rng};
        den_nxt[c]     = {rng, 1'b0};
        q_nxt[c]       = '0;
        ovr_nxt[c]     = (hi_r[c] <= lo_r[c]) || (px[c] < lo_r[c]) || (px[c] > hi_r[c]);
        ovr_val_nxt[c] = ((hi_r[c] > lo_r[c]) && (px[c] > hi_r[c])) ? FULL_SCALE : '0;
      end

      // restoring step: subtract the shifted divisor if it fits
      if (cmd.step) begin
        dsh   = NUM_W'(den_r[c]) << cmd.bit_idx;
        trial = {1'b0, rem_r[c]} - {1'b0, dsh};
        if (!trial[NUM_W]) begin
          rem_nxt[c] = trial[NUM_W-1:0];
          q_nxt[c]   = {q_r[c][PIX_W-2:0], 1'b1};
        end else begin
          q_nxt[c]   = {q_r[c][PIX_W-2:0], 1'b0};
        end
      end

      res[c] = ovr_r[c] ? ovr_val_r[c] : q_r[c];
    end
  end

  // output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit) begin
      out_nxt = '{red_out: res[0], green_out: res[1], blue_out: res[2], alpha_out: res[3]};
      out_valid_nxt = 1'b1;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  // control and mark registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_alpha_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        lo_r[c] <= '0;
        hi_r[c] <= '0;
      end
    end else begin
      if (cfg_wr_en) has_alpha_r <= cfg_wr_data;
      out_valid_r <= out_valid_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        lo_r[c] <= lo_nxt[c];
        hi_r[c] <= hi_nxt[c];
      end
    end
  end

  // divider and output payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    for (int c = 0; c < NUM_CH; c++) begin
      rem_r[c]     <= rem_nxt[c];
      den_r[c]     <= den_nxt[c];
      q_r[c]       <= q_nxt[c];
      ovr_r[c]     <= ovr_nxt[c];
      ovr_val_r[c] <= ovr_val_nxt[c];
    end
  end

  `CSM_ASSERT_NOW(a_marks_ordered, 1'b1, (lo_r[0] <= hi_r[0]) && (lo_r[1] <= hi_r[1]) && (lo_r[2] <= hi_r[2]) && (lo_r[3] <= hi_r[3]), "minimum mark above maximum mark")
  `CSM_ASSERT_NEXT(a_first_reload, cmd.measure && in_data.first, (lo_r[0] == hi_r[0]) && (lo_r[1] == hi_r[1]) && (lo_r[2] == hi_r[2]) && (lo_r[3] == hi_r[3]), "first pixel did not reload both marks")
  `CSM_ASSERT_NEXT(a_emit_fills_out, cmd.emit, out_valid_r, "emit did not fill the output register")

endmodule

`default_nettype wire

// File: hdl/contrast_stretch_minmax.sv
// Per-channel min/max contrast stretch of RGBA pixels in two passes. Measure
// items (func 0) update the per-channel minimum and maximum; adjust items
// (func 1) form numerator and divisor, run eight steps of the four-lane
// restoring divider (one quotient bit per step), then load the output register
// once it is no longer held by the consumer. One item is in work at a time; the
// output register lets the next item be transferred while a result waits.
// Depends on csm_pkg, csm_ctrl, csm_dp.
`default_nettype none

module contrast_stretch_minmax
  import csm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cfg_wr_en,
  input  wire logic    cfg_wr_data,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire csm_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output csm_out_t     out_data
);

  csm_cmd_t cmd;
  csm_sts_t sts;

  // sequencing
  csm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_data.func),
    .sts      (sts),
    .cmd      (cmd)
  );

  // marks, divider and output register
  csm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
